### rtl/hcbr_pkg.sv
// ----------------------------------------------------------------------------
// hcbr_pkg
// Shared constants of the host CAN bridge register window.
// ----------------------------------------------------------------------------
package hcbr_pkg;

  localparam int unsigned MsgBytes = 16;
  localparam int unsigned FifoMsgs = 8;
  localparam int unsigned BufBytes = 16;

  localparam logic [7:0] BadRegByte = 8'h55;
  localparam int unsigned SmallRegBytes = 8;

  localparam logic [2:0] CmdAddr   = 3'd0;
  localparam logic [2:0] CmdStatus = 3'd1;
  localparam logic [2:0] CmdWrite  = 3'd2;
  localparam logic [2:0] CmdRead   = 3'd3;
  localparam logic [2:0] CmdRx     = 3'd4;
  localparam logic [2:0] CmdTxFree = 3'd5;

  localparam logic [3:0] RegCan  = 4'd0;
  localparam logic [3:0] RegFilt1 = 4'd1;
  localparam logic [3:0] RegFilt2 = 4'd2;
  localparam logic [3:0] RegCfg  = 4'd3;

endpackage

### rtl/host_can_bridge_registers.sv
// ----------------------------------------------------------------------------
// host_can_bridge_registers
// Host-side byte register window of a CAN bridge with an rx message FIFO.
// ----------------------------------------------------------------------------
// Each accepted item gets a registered result through S_OUT; the next item is taken
// only once that result has left. A data read adds S_RD, a CAN read that pops the FIFO
// adds S_POP and S_RD, a config read adds S_CFGRD and S_RD, a completed filter or
// config write adds S_FILT or S_CFG, and a short rx message adds S_ZERO for its zero bytes.
// A CAN transmit gives MSG_BYTES results from S_TX, each once the one before has left.
// Reset is asynchronous; after it, S_CLR sweeps all BUF_BYTES entries to clear rbuf.
module host_can_bridge_registers #(
  parameter int unsigned MSG_BYTES = hcbr_pkg::MsgBytes,
  parameter int unsigned FIFO_MSGS = hcbr_pkg::FifoMsgs,
  parameter int unsigned BUF_BYTES = hcbr_pkg::BufBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  byte_in_i,
  input  logic        msg_last_i,
  input  logic        tx_free_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  rd_byte_o,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic        filt_valid_o,
  output logic        filt_index_o,
  output logic [31:0] filt_id_o,
  output logic [31:0] filt_mask_o,
  output logic [31:0] cfg_value_o,
  output logic        int_n_o,
  output logic        last_o
);

  localparam int unsigned BW  = $clog2(BUF_BYTES);
  localparam int unsigned MW  = $clog2(MSG_BYTES);
  localparam int unsigned FW  = (FIFO_MSGS > 1) ? $clog2(FIFO_MSGS) : 1;
  localparam int unsigned CW  = $clog2(FIFO_MSGS + 1);
  localparam int unsigned AW  = $clog2(FIFO_MSGS * MSG_BYTES);
  localparam int unsigned PW  = BW + 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_FILT, S_CFG, S_CFGRD, S_TX, S_POP, S_RD, S_ZERO, S_OUT
  } state_e;

  // Memories.
  logic [7:0] wbuf_mem [BUF_BYTES];
  logic [7:0] rbuf_mem [BUF_BYTES];
  logic [7:0] fifo_mem [FIFO_MSGS * MSG_BYTES];
  logic [7:0] wbuf_rd_q, rbuf_rd_q, fifo_rd_q;

  state_e      state_q;
  logic [3:0]  reg_sel_q, irq_en_q;
  logic        ovf_q, txe_q, irq_q;
  logic [PW-1:0] wptr_q, rptr_q;
  logic [31:0] cfg_q;
  logic [FW-1:0] head_q, tail_q;
  logic [CW-1:0] count_q;
  logic [MW:0] asm_q;
  logic [PW-1:0] idx_q;     // sweep counter
  logic [63:0] acc_q;       // gathered filter/config bytes
  logic        rd_valid_q;  // rd byte comes from rbuf read port
  logic [BW-1:0] raddr_q;   // rbuf entry returned by the current read

  logic        ov_q;
  logic [7:0]  rd_q, txb_q;
  logic        txv_q, txl_q, fv_q, fi_q, lst_q;
  logic [31:0] fid_q, fm_q;

  // Memory port controls (combinational).
  logic          wb_we, rb_we, ff_we;
  logic [BW-1:0] wb_wa, wb_ra, rb_wa, rb_ra;
  logic [7:0]    wb_wd, rb_wd, ff_wd;
  logic [AW-1:0] ff_wa, ff_ra;

  logic [PW-1:0] reg_sz;
  logic          accept;
  logic [31:0]   gath_id, gath_mask;

  always_comb begin
    case (reg_sel_q)
      hcbr_pkg::RegCan: reg_sz = PW'(MSG_BYTES);
      hcbr_pkg::RegFilt1, hcbr_pkg::RegFilt2, hcbr_pkg::RegCfg:
        reg_sz = PW'(hcbr_pkg::SmallRegBytes);
      default: reg_sz = '0;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE) || ov_q;
  assign accept     = in_valid_i && !in_stall_o;

  // When idx_q reaches SmallRegBytes, acc_q holds bytes 0..6 and the read port byte 7.
  assign gath_id   = acc_q[39:8];
  assign gath_mask = {wbuf_rd_q, acc_q[63:40]};

  function automatic logic [AW-1:0] fifo_addr(input logic [FW-1:0] slot,
                                              input logic [MW-1:0] ofs);
    fifo_addr = AW'(slot * MSG_BYTES + ofs);
  endfunction

  always_comb begin
    logic [PW-1:0] wp;
    logic          full;
    wp = (wptr_q >= reg_sz) ? '0 : wptr_q;
    full = (count_q >= CW'(FIFO_MSGS));
    wb_we = 1'b0; wb_wa = wp[BW-1:0]; wb_wd = byte_in_i;
    // During a transmit the read port holds the byte about to be sent.
    wb_ra = (state_q == S_TX && idx_q != '0) ? BW'(idx_q - 1'b1) : idx_q[BW-1:0];
    rb_we = 1'b0; rb_wa = idx_q[BW-1:0]; rb_wd = fifo_rd_q;
    rb_ra = raddr_q;
    ff_we = 1'b0; ff_wa = fifo_addr(tail_q, asm_q[MW-1:0]); ff_wd = byte_in_i;
    ff_ra = fifo_addr(head_q, idx_q[MW-1:0]);
    if (state_q == S_IDLE) begin
      if (accept && cmd_i == hcbr_pkg::CmdWrite && reg_sz != '0) wb_we = 1'b1;
      if (accept && cmd_i == hcbr_pkg::CmdRx && !full && asm_q < (MW+1)'(MSG_BYTES))
        ff_we = 1'b1;
    end
    if (state_q == S_POP && idx_q != '0) begin
      rb_we = 1'b1;
      rb_wa = BW'(idx_q - 1'b1);
    end
    if (state_q == S_POP) ff_ra = fifo_addr(head_q, idx_q[MW-1:0]);
    if (state_q == S_ZERO) begin
      ff_we = 1'b1; ff_wd = 8'h00;
    end
    if (state_q == S_CLR) begin
      rb_we = 1'b1; rb_wd = 8'h00;
    end
    // Config snapshot: the word little-endian in bytes 0..3, zeros above.
    if (state_q == S_CFGRD) begin
      rb_we = 1'b1;
      rb_wd = (idx_q < PW'(4)) ? 8'(cfg_q >> {idx_q[1:0], 3'b000}) : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_we) wbuf_mem[wb_wa] <= wb_wd;
    wbuf_rd_q <= wbuf_mem[wb_ra];
    if (rb_we) rbuf_mem[rb_wa] <= rb_wd;
    rbuf_rd_q <= rbuf_mem[rb_ra];
    if (ff_we) fifo_mem[ff_wa] <= ff_wd;
    fifo_rd_q <= fifo_mem[ff_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [PW-1:0] wp;
    logic [PW-1:0] rp;
    logic          full;
    if (!rst_ni) begin
      state_q <= S_CLR;
      reg_sel_q <= '0; irq_en_q <= '0; ovf_q <= 1'b0; txe_q <= 1'b0;
      irq_q <= 1'b1; wptr_q <= '0; rptr_q <= '0; cfg_q <= '0;
      head_q <= '0; tail_q <= '0; count_q <= '0; asm_q <= '0;
      idx_q <= '0; ov_q <= 1'b0; rd_valid_q <= 1'b0; raddr_q <= '0;
    end else begin
      wp = (wptr_q >= reg_sz) ? '0 : wptr_q;
      rp = (rptr_q >= reg_sz) ? '0 : rptr_q;
      full = (count_q >= CW'(FIFO_MSGS));
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        // Clear the read buffer once after reset.
        S_CLR: begin
          if (idx_q == PW'(BUF_BYTES - 1)) begin
            idx_q <= '0;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            rd_q <= '0; txv_q <= 1'b0; txb_q <= '0; txl_q <= 1'b0;
            fv_q <= 1'b0; fi_q <= 1'b0; fid_q <= '0; fm_q <= '0;
            lst_q <= 1'b1; rd_valid_q <= 1'b0;
            state_q <= S_OUT;
            case (cmd_i)
              hcbr_pkg::CmdAddr: begin
                rptr_q <= '0; wptr_q <= '0;
                reg_sel_q <= byte_in_i[7:4]; irq_en_q <= byte_in_i[3:0];
                if (byte_in_i[2]) ovf_q <= 1'b0;
              end
              hcbr_pkg::CmdStatus: begin
                rptr_q <= '0; wptr_q <= '0; irq_q <= 1'b1;
                rd_q <= {reg_sel_q, 1'b0, ovf_q, tx_free_i, count_q != '0};
              end
              hcbr_pkg::CmdWrite: begin
                if (reg_sz != '0) begin
                  if (wp + 1'b1 == reg_sz) begin
                    wptr_q <= '0;
                    idx_q <= '0;
                    if (reg_sel_q == hcbr_pkg::RegCan) state_q <= S_TX;
                    else if (reg_sel_q == hcbr_pkg::RegCfg) state_q <= S_CFG;
                    else state_q <= S_FILT;
                  end else begin
                    wptr_q <= wp + 1'b1;
                  end
                end
              end
              hcbr_pkg::CmdRead: begin
                if (reg_sz == '0) begin
                  rd_q <= hcbr_pkg::BadRegByte;
                end else begin
                  rptr_q <= (rp + 1'b1 == reg_sz) ? '0 : rp + 1'b1;
                  rd_valid_q <= 1'b1;
                  raddr_q <= rp[BW-1:0];
                  idx_q <= '0;
                  state_q <= S_RD;
                  if (rp == '0 && reg_sel_q == hcbr_pkg::RegCan && count_q != '0) begin
                    state_q <= S_POP;
                  end else if (rp == '0 && reg_sel_q == hcbr_pkg::RegCfg) begin
                    state_q <= S_CFGRD;
                  end
                end
              end
              hcbr_pkg::CmdRx: begin
                if (asm_q < (MW+1)'(MSG_BYTES)) asm_q <= asm_q + 1'b1;
                if (msg_last_i) begin
                  if (irq_en_q[0]) irq_q <= 1'b0;
                  if (full) begin
                    ovf_q <= 1'b1;
                    asm_q <= '0;
                  end else if (asm_q + 1'b1 < (MW+1)'(MSG_BYTES) &&
                               asm_q < (MW+1)'(MSG_BYTES)) begin
                    asm_q <= asm_q + 1'b1;
                    state_q <= S_ZERO;
                  end else begin
                    asm_q <= '0;
                    tail_q <= (tail_q == FW'(FIFO_MSGS - 1)) ? '0 : tail_q + 1'b1;
                    count_q <= count_q + 1'b1;
                  end
                end
              end
              hcbr_pkg::CmdTxFree: begin
                txe_q <= 1'b1;
                if (irq_en_q[1]) irq_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        // Zero fill the unwritten tail of the slot, then commit it.
        S_ZERO: begin
          if (asm_q == (MW+1)'(MSG_BYTES - 1)) begin
            asm_q <= '0;
            tail_q <= (tail_q == FW'(FIFO_MSGS - 1)) ? '0 : tail_q + 1'b1;
            count_q <= count_q + 1'b1;
            state_q <= S_OUT;
          end else begin
            asm_q <= asm_q + 1'b1;
          end
        end
        // Copy the head slot into the read buffer; memory read leads by one.
        S_POP: begin
          if (idx_q == PW'(MSG_BYTES)) begin
            head_q <= (head_q == FW'(FIFO_MSGS - 1)) ? '0 : head_q + 1'b1;
            count_q <= count_q - 1'b1;
            state_q <= S_RD;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        // Write the config snapshot into the read buffer, one byte a cycle.
        S_CFGRD: begin
          if (idx_q == PW'(hcbr_pkg::SmallRegBytes - 1)) state_q <= S_RD;
          idx_q <= idx_q + 1'b1;
        end
        // rbuf read address is raddr_q; wait for registered data.
        S_RD: state_q <= S_OUT;
        // Gather the 8 bytes of the write buffer into acc_q, then emit the filter or update cfg_q under the mask.
        S_FILT, S_CFG: begin
          if (idx_q != '0) acc_q <= {wbuf_rd_q, acc_q[63:8]};
          if (idx_q == PW'(hcbr_pkg::SmallRegBytes)) begin
            if (state_q == S_FILT) begin
              fv_q <= 1'b1;
              fi_q <= (reg_sel_q == hcbr_pkg::RegFilt2);
              fid_q <= gath_id;
              fm_q <= gath_mask;
            end else begin
              cfg_q <= (cfg_q & ~gath_mask) | (gath_id & gath_mask);
            end
            state_q <= S_OUT;
          end
          idx_q <= idx_q + 1'b1;
        end
        S_TX: begin
          if (idx_q != '0 && !ov_q) begin
            ov_q <= 1'b1;
            txv_q <= 1'b1; txb_q <= wbuf_rd_q;
            txl_q <= (idx_q == PW'(MSG_BYTES));
            lst_q <= (idx_q == PW'(MSG_BYTES));
            if (idx_q == PW'(MSG_BYTES)) state_q <= S_IDLE;
            else idx_q <= idx_q + 1'b1;
          end else if (idx_q == '0) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_OUT: begin
          if (rd_valid_q) rd_q <= rbuf_rd_q;
          rd_valid_q <= 1'b0;
          ov_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = ov_q;
  assign rd_byte_o    = rd_q;
  assign tx_valid_o   = txv_q;
  assign tx_byte_o    = txb_q;
  assign tx_last_o    = txl_q;
  assign filt_valid_o = fv_q;
  assign filt_index_o = fi_q;
  assign filt_id_o    = fid_q;
  assign filt_mask_o  = fm_q;
  assign cfg_value_o  = cfg_q;
  assign int_n_o      = irq_q;
  assign last_o       = lst_q;

endmodule
